// ===== hw/rtl/ibdp_pkg.sv =====
// Package for the indoor bike data parser: request types, flag layout constants
// and the function that turns a flag word into field offsets.
// Used by every module of the block; depends on nothing.
package ibdp_pkg;

  // Defaults and widths.
  localparam int unsigned PositionLimitDefault = 63;
  localparam int unsigned OffsetWidth          = 5;
  localparam int unsigned NumFields            = 4;

  // Result mask bits and field indexes.
  localparam int unsigned FieldSpeed   = 0;
  localparam int unsigned FieldCadence = 1;
  localparam int unsigned FieldPower   = 2;
  localparam int unsigned FieldElapsed = 3;

  // Flag word bits in the published layout.
  localparam int unsigned FlagMoreData   = 0;  // set means speed is absent
  localparam int unsigned FlagAvgSpeed   = 1;
  localparam int unsigned FlagCadence    = 2;
  localparam int unsigned FlagAvgCadence = 3;
  localparam int unsigned FlagDistance   = 4;
  localparam int unsigned FlagResistance = 5;
  localparam int unsigned FlagPower      = 6;
  localparam int unsigned FlagAvgPower   = 7;
  localparam int unsigned FlagEnergy     = 8;
  localparam int unsigned FlagHeartRate  = 9;
  localparam int unsigned FlagMet        = 10;
  localparam int unsigned FlagElapsed    = 11;

  // Byte lengths of the fields and the first field offset.
  localparam int unsigned FirstOffset = 2;
  localparam int unsigned LenWord     = 2;
  localparam int unsigned LenDistance = 3;
  localparam int unsigned LenEnergy   = 5;
  localparam int unsigned LenByte     = 1;

  // Cadence saturation value.
  localparam logic [7:0] CadenceMax = 8'hFF;

  typedef logic [OffsetWidth-1:0] offset_t;

  // One input request: a notification byte with its end mark.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  // One result request.
  typedef struct packed {
    logic [15:0] speed;
    logic [7:0]  cadence;
    logic [15:0] power;
    logic [15:0] elapsed_secs;
    logic [3:0]  fields_updated;
  } out_t;

  // Offsets and presence of the four tracked fields.
  typedef struct packed {
    offset_t [NumFields-1:0]  off;
    logic    [NumFields-1:0]  present;
  } layout_t;

  // Adds the length of each flagged field in turn to find the tracked offsets.
  function automatic layout_t layout_from_flags(logic [15:0] flags);
    offset_t acc;
    layout_t lay;
    acc = offset_t'(FirstOffset);
    lay.present[FieldSpeed] = !flags[FlagMoreData];
    lay.off[FieldSpeed]     = acc;
    acc = acc + (lay.present[FieldSpeed] ? offset_t'(LenWord) : '0);
    acc = acc + (flags[FlagAvgSpeed] ? offset_t'(LenWord) : '0);
    lay.present[FieldCadence] = flags[FlagCadence];
    lay.off[FieldCadence]     = acc;
    acc = acc + (flags[FlagCadence] ? offset_t'(LenWord) : '0);
    acc = acc + (flags[FlagAvgCadence] ? offset_t'(LenWord) : '0);
    acc = acc + (flags[FlagDistance] ? offset_t'(LenDistance) : '0);
    acc = acc + (flags[FlagResistance] ? offset_t'(LenWord) : '0);
    lay.present[FieldPower] = flags[FlagPower];
    lay.off[FieldPower]     = acc;
    acc = acc + (flags[FlagPower] ? offset_t'(LenWord) : '0);
    acc = acc + (flags[FlagAvgPower] ? offset_t'(LenWord) : '0);
    acc = acc + (flags[FlagEnergy] ? offset_t'(LenEnergy) : '0);
    acc = acc + (flags[FlagHeartRate] ? offset_t'(LenByte) : '0);
    acc = acc + (flags[FlagMet] ? offset_t'(LenByte) : '0);
    lay.present[FieldElapsed] = flags[FlagElapsed];
    lay.off[FieldElapsed]     = acc;
    return lay;
  endfunction

endpackage

// ===== hw/rtl/ibdp_in_reg.sv =====
// Input register of the indoor bike data parser: holds one byte request
// until the capture stage takes it. Depends on ibdp_pkg.
module ibdp_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ibdp_pkg::in_t in_data_i,
  input  logic          take_i,
  output logic          valid_o,
  output ibdp_pkg::in_t data_o
);

  logic          valid_q, valid_d;
  ibdp_pkg::in_t data_q, data_d;

  // The register is free when empty or when its request leaves this cycle.
  assign in_stall_o = valid_q && !take_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (!in_stall_o) begin
      valid_d = in_valid_i;
      data_d  = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hw/rtl/ibdp_layout.sv =====
// Field layout register: turns the flag word of the current packet into the
// offsets of speed, cadence, power and elapsed time. Depends on ibdp_pkg.
module ibdp_layout (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic [15:0]       flags_i,
  output ibdp_pkg::layout_t layout_o
);

  ibdp_pkg::layout_t layout_q, layout_d;

  // Offsets are worked out once, when the high flag byte arrives.
  always_comb begin
    layout_d = layout_q;
    if (load_i) begin
      layout_d = ibdp_pkg::layout_from_flags(flags_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layout_q <= ibdp_pkg::layout_from_flags('0);
    end else begin
      layout_q <= layout_d;
    end
  end

  assign layout_o = layout_q;

endmodule

// ===== hw/rtl/ibdp_capture.sv =====
// Capture stage: tracks the byte position, assembles the tracked fields into
// held registers and drives the result register. Depends on ibdp_pkg.
module ibdp_capture #(
  parameter int unsigned POSITION_LIMIT = ibdp_pkg::PositionLimitDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  ibdp_pkg::in_t     data_i,
  output logic              take_o,
  input  ibdp_pkg::layout_t layout_i,
  output logic              layout_load_o,
  output logic [15:0]       flags_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ibdp_pkg::out_t    out_data_o
);

  localparam int unsigned PosWidth = $clog2(POSITION_LIMIT + 1);

  logic [PosWidth-1:0] pos_q, pos_d;
  logic [7:0]          flag_lo_q, flag_lo_d;
  logic [7:0]          pending_q, pending_d;
  logic [15:0]         speed_q, speed_d;
  logic [7:0]          cadence_q, cadence_d;
  logic [15:0]         power_q, power_d;
  logic [15:0]         elapsed_q, elapsed_d;
  logic [ibdp_pkg::NumFields-1:0] mask_q, mask_d, mask_upd;
  logic                out_valid_q, out_valid_d;
  ibdp_pkg::out_t      out_q, out_d;
  logic                step;
  logic                emit;
  logic [15:0]         word;
  logic [ibdp_pkg::NumFields-1:0] hit_lo, hit_hi;

  // A request moves on when the result register is free or being emptied.
  assign take_o = valid_i && (!out_valid_q || !out_stall_i);
  assign step   = take_o;
  assign emit   = data_i.last_byte && (pos_q != '0);
  assign word   = {data_i.data_byte, pending_q};

  assign layout_load_o = step && (pos_q == PosWidth'(1));
  assign flags_o       = {data_i.data_byte, flag_lo_q};

  // Match the position against each field's low and high byte.
  always_comb begin
    for (int i = 0; i < ibdp_pkg::NumFields; i++) begin
      hit_lo[i] = layout_i.present[i] && (pos_q == PosWidth'(layout_i.off[i]));
      hit_hi[i] = layout_i.present[i] &&
                  (pos_q == PosWidth'(layout_i.off[i] + ibdp_pkg::offset_t'(1)));
    end
  end

  // Field assembly and held values.
  always_comb begin
    flag_lo_d = flag_lo_q;
    pending_d = pending_q;
    speed_d   = speed_q;
    cadence_d = cadence_q;
    power_d   = power_q;
    elapsed_d = elapsed_q;
    mask_upd  = mask_q;
    if (pos_q == '0) begin
      flag_lo_d = data_i.data_byte;
    end else if (pos_q != PosWidth'(1)) begin
      if (|hit_lo) begin
        pending_d = data_i.data_byte;
      end
      if (hit_hi[ibdp_pkg::FieldSpeed]) begin
        speed_d = word;
      end
      if (hit_hi[ibdp_pkg::FieldCadence]) begin
        cadence_d = (word[15:9] != '0) ? ibdp_pkg::CadenceMax : word[8:1];
      end
      if (hit_hi[ibdp_pkg::FieldPower]) begin
        power_d = word;
      end
      if (hit_hi[ibdp_pkg::FieldElapsed]) begin
        elapsed_d = word;
      end
      mask_upd = mask_q | hit_hi;
    end
  end

  // Position counter and per-packet mask; both clear after the last byte.
  always_comb begin
    pos_d  = (pos_q < PosWidth'(POSITION_LIMIT)) ? pos_q + PosWidth'(1) : pos_q;
    mask_d = mask_upd;
    if (data_i.last_byte) begin
      pos_d  = '0;
      mask_d = '0;
    end
  end

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (step && emit) begin
      out_valid_d          = 1'b1;
      out_d.speed          = speed_d;
      out_d.cadence        = cadence_d;
      out_d.power          = power_d;
      out_d.elapsed_secs   = elapsed_d;
      out_d.fields_updated = mask_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      flag_lo_q   <= '0;
      pending_q   <= '0;
      speed_q     <= '0;
      cadence_q   <= '0;
      power_q     <= '0;
      elapsed_q   <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (step) begin
        pos_q     <= pos_d;
        flag_lo_q <= flag_lo_d;
        pending_q <= pending_d;
        speed_q   <= speed_d;
        cadence_q <= cadence_d;
        power_q   <= power_d;
        elapsed_q <= elapsed_d;
        mask_q    <= mask_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/indoor_bike_data_parser.sv =====
// Top level of the indoor bike data parser: input register, field layout
// register and capture stage. Depends on ibdp_pkg and the ibdp_* modules.
//
//   Channel | Handshake               | Payload
//   --------+-------------------------+----------------------------------------
//   in      | in_valid_i / in_stall_o | in_data_i  (data_byte, last_byte)
//   out     | out_valid_o / out_stall_i | out_data_o (held fields, update mask)
//
// One byte request is taken per cycle while in_stall_o is low; each request is held
// in the input register until the capture stage takes it and processes it into the result register.
// A result is registered as valid when the capture stage takes its last byte.
// Reset clears the position, low flag byte, held fields and both valid flags.
// A held result stalls the capture stage, which in turn stalls the input.
module indoor_bike_data_parser #(
  parameter int unsigned POSITION_LIMIT = ibdp_pkg::PositionLimitDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ibdp_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ibdp_pkg::out_t out_data_o
);

  logic              take;
  logic              reg_valid;
  ibdp_pkg::in_t     reg_data;
  logic              layout_load;
  logic [15:0]       flags;
  ibdp_pkg::layout_t layout;

  // Input register.
  ibdp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .take_i     (take),
    .valid_o    (reg_valid),
    .data_o     (reg_data)
  );

  // Field offsets of the current packet.
  ibdp_layout u_layout (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (layout_load),
    .flags_i  (flags),
    .layout_o (layout)
  );

  // Field capture and result register.
  ibdp_capture #(
    .POSITION_LIMIT (POSITION_LIMIT)
  ) u_capture (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (reg_valid),
    .data_i        (reg_data),
    .take_o        (take),
    .layout_i      (layout),
    .layout_load_o (layout_load),
    .flags_o       (flags),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

endmodule

// ===== test/tb_indoor_bike_data_parser.sv =====
// Testbench for the indoor bike data parser: drives notification bytes, predicts
// the held fields and update mask per packet, and checks every result.
// Depends on ibdp_pkg and the indoor_bike_data_parser RTL.
module tb_indoor_bike_data_parser;

  localparam int unsigned PositionLimit = ibdp_pkg::PositionLimitDefault;
  localparam int unsigned NumRequests   = 1850;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned ReportLimit   = 10;

  // Tracks the parser state and the reports that packets should produce.
  class bike_data_scoreboard;
    int unsigned    position;
    logic [15:0]    flag_bits;
    logic [7:0]     low_byte;
    logic [15:0]    speed;
    logic [7:0]     cadence;
    logic [15:0]    power;
    logic [15:0]    elapsed;
    logic [3:0]     mask;
    ibdp_pkg::out_t expected_reports [$];
    int unsigned    mismatches;

    function new();
      position   = 0;
      flag_bits  = '0;
      low_byte   = '0;
      speed      = '0;
      cadence    = '0;
      power      = '0;
      elapsed    = '0;
      mask       = '0;
      mismatches = 0;
    endfunction

    function int unsigned outstanding();
      return expected_reports.size();
    endfunction

    // Applies one accepted byte and queues a report on the final byte of a packet of two or more bytes.
    function void parse_byte(ibdp_pkg::in_t req);
      int unsigned    pos;
      int unsigned    at;
      int unsigned    off [ibdp_pkg::NumFields];
      bit             have [ibdp_pkg::NumFields];
      logic [15:0]    word;
      ibdp_pkg::out_t rep;
      pos = position;
      if (pos == 0) begin
        flag_bits[7:0] = req.data_byte;
      end else if (pos == 1) begin
        flag_bits[15:8] = req.data_byte;
      end else begin
        // Walk the flagged fields in order to find where the tracked ones sit.
        at = ibdp_pkg::FirstOffset;
        have[ibdp_pkg::FieldSpeed] = !flag_bits[ibdp_pkg::FlagMoreData];
        off[ibdp_pkg::FieldSpeed]  = at;
        if (have[ibdp_pkg::FieldSpeed]) at += ibdp_pkg::LenWord;
        if (flag_bits[ibdp_pkg::FlagAvgSpeed]) at += ibdp_pkg::LenWord;
        have[ibdp_pkg::FieldCadence] = flag_bits[ibdp_pkg::FlagCadence];
        off[ibdp_pkg::FieldCadence]  = at;
        if (flag_bits[ibdp_pkg::FlagCadence]) at += ibdp_pkg::LenWord;
        if (flag_bits[ibdp_pkg::FlagAvgCadence]) at += ibdp_pkg::LenWord;
        if (flag_bits[ibdp_pkg::FlagDistance]) at += ibdp_pkg::LenDistance;
        if (flag_bits[ibdp_pkg::FlagResistance]) at += ibdp_pkg::LenWord;
        have[ibdp_pkg::FieldPower] = flag_bits[ibdp_pkg::FlagPower];
        off[ibdp_pkg::FieldPower]  = at;
        if (flag_bits[ibdp_pkg::FlagPower]) at += ibdp_pkg::LenWord;
        if (flag_bits[ibdp_pkg::FlagAvgPower]) at += ibdp_pkg::LenWord;
        if (flag_bits[ibdp_pkg::FlagEnergy]) at += ibdp_pkg::LenEnergy;
        if (flag_bits[ibdp_pkg::FlagHeartRate]) at += ibdp_pkg::LenByte;
        if (flag_bits[ibdp_pkg::FlagMet]) at += ibdp_pkg::LenByte;
        have[ibdp_pkg::FieldElapsed] = flag_bits[ibdp_pkg::FlagElapsed];
        off[ibdp_pkg::FieldElapsed]  = at;
        for (int i = 0; i < ibdp_pkg::NumFields; i++) begin
          if (have[i] && pos == off[i]) begin
            low_byte = req.data_byte;
          end else if (have[i] && pos == off[i] + 1) begin
            word = {req.data_byte, low_byte};
            case (i)
              ibdp_pkg::FieldSpeed:   speed = word;
              ibdp_pkg::FieldCadence:
                cadence = (word[15:1] > 15'd255) ? ibdp_pkg::CadenceMax : word[8:1];
              ibdp_pkg::FieldPower:   power = word;
              default:                elapsed = word;
            endcase
            mask[i] = 1'b1;
          end
        end
      end
      if (position < PositionLimit) position++;
      // A packet of two or more bytes reports; a lone byte only clears state.
      if (req.last_byte) begin
        if (pos >= 1) begin
          rep.speed          = speed;
          rep.cadence        = cadence;
          rep.power          = power;
          rep.elapsed_secs   = elapsed;
          rep.fields_updated = mask;
          expected_reports.push_back(rep);
        end
        position = 0;
        mask     = '0;
      end
    endfunction

    // Compares one accepted report with the oldest expected one.
    function void check_result(ibdp_pkg::out_t got);
      ibdp_pkg::out_t exp;
      bit             bad;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("unexpected report: speed %h cadence %h power %h elapsed %h mask %b",
                   got.speed, got.cadence, got.power, got.elapsed_secs, got.fields_updated);
        end
        return;
      end
      exp = expected_reports.pop_front();
      bad = 1'b0;
      if (got.speed !== exp.speed) bad = 1'b1;
      if (got.cadence !== exp.cadence) bad = 1'b1;
      if (got.power !== exp.power) bad = 1'b1;
      if (got.elapsed_secs !== exp.elapsed_secs) bad = 1'b1;
      if (got.fields_updated !== exp.fields_updated) bad = 1'b1;
      if (bad) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("report mismatch (expected/actual): speed %h/%h cadence %h/%h",
                   exp.speed, got.speed, exp.cadence, got.cadence);
          $display("  power %h/%h elapsed %h/%h mask %b/%b",
                   exp.power, got.power, exp.elapsed_secs, got.elapsed_secs,
                   exp.fields_updated, got.fields_updated);
        end
      end
    endfunction
  endclass

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_stall_o;
  ibdp_pkg::in_t  in_data_i;
  logic           out_valid_o;
  logic           out_stall_i;
  ibdp_pkg::out_t out_data_o;

  bike_data_scoreboard sb = new();

  int unsigned sent_count;
  int unsigned taken_count;
  int unsigned idle_cycles;
  bit          hold_req;

  indoor_bike_data_parser #(
    .POSITION_LIMIT(PositionLimit)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Sample both handshakes at the rising edge and watch for a hang.
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) sb.parse_byte(in_data_i);
    if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offers one byte request after a random gap and waits until it is taken.
  task automatic send_byte(input logic [7:0] data, input logic last);
    int unsigned gap;
    gap = (sent_count % 200 < 50) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{data_byte: data, last_byte: last};
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    sent_count++;
  endtask

  // Lets the parser drain every pending report before going on.
  task automatic wait_for_reports();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Result side: random stall before each report, one long hold on request.
  initial begin : receiver
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      n = (taken_count % 60 < 15) ? 0 : $urandom_range(0, 19);
      if (hold_req) begin
        n        = HoldCycles;
        hold_req = 1'b0;
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
      taken_count++;
    end
  end

  // Directed packets: lone byte, maximum speed, cadence at the saturation edge
  // with power and elapsed time, a truncated field, a flag-only packet and a
  // cadence far above the saturation point.
  ibdp_pkg::in_t script [22] = '{
    '{8'hFF, 1'b1},
    '{8'h00, 1'b0}, '{8'h00, 1'b0}, '{8'hFF, 1'b0}, '{8'hFF, 1'b1},
    '{8'h45, 1'b0}, '{8'h08, 1'b0}, '{8'hFE, 1'b0}, '{8'h01, 1'b0},
    '{8'h00, 1'b0}, '{8'h00, 1'b0}, '{8'hFF, 1'b0}, '{8'hFF, 1'b1},
    '{8'h04, 1'b0}, '{8'h00, 1'b0}, '{8'h80, 1'b1},
    '{8'hFF, 1'b0}, '{8'hFF, 1'b1},
    '{8'h05, 1'b0}, '{8'h00, 1'b0}, '{8'hFF, 1'b0}, '{8'hFF, 1'b1}
  };

  initial begin : stimulus
    logic [15:0] flags;
    logic [7:0]  data;
    int unsigned full;
    int unsigned len;
    int unsigned kind;
    bit          held_once;
    bit          drained_once;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    sent_count  = 0;
    taken_count = 0;
    idle_cycles = 0;
    hold_req    = 1'b0;
    held_once    = 1'b0;
    drained_once = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) send_byte(script[i].data_byte, script[i].last_byte);
    wait_for_reports();

    // Random packets: mostly complete or padded, some truncated, long or noise.
    while (sent_count < NumRequests) begin
      flags = 16'($urandom());
      full = 2 + (flags[ibdp_pkg::FlagMoreData] ? 0 : ibdp_pkg::LenWord)
               + (flags[ibdp_pkg::FlagAvgSpeed] ? ibdp_pkg::LenWord : 0)
               + (flags[ibdp_pkg::FlagCadence] ? ibdp_pkg::LenWord : 0)
               + (flags[ibdp_pkg::FlagAvgCadence] ? ibdp_pkg::LenWord : 0)
               + (flags[ibdp_pkg::FlagDistance] ? ibdp_pkg::LenDistance : 0)
               + (flags[ibdp_pkg::FlagResistance] ? ibdp_pkg::LenWord : 0)
               + (flags[ibdp_pkg::FlagPower] ? ibdp_pkg::LenWord : 0)
               + (flags[ibdp_pkg::FlagAvgPower] ? ibdp_pkg::LenWord : 0)
               + (flags[ibdp_pkg::FlagEnergy] ? ibdp_pkg::LenEnergy : 0)
               + (flags[ibdp_pkg::FlagHeartRate] ? ibdp_pkg::LenByte : 0)
               + (flags[ibdp_pkg::FlagMet] ? ibdp_pkg::LenByte : 0)
               + (flags[ibdp_pkg::FlagElapsed] ? ibdp_pkg::LenWord : 0);
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        len = full + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
      end else if (kind < 80) begin
        len = (full > 2) ? $urandom_range(2, full - 1) : 2;
      end else if (kind < 85) begin
        len = $urandom_range(PositionLimit - 3, PositionLimit + 9);
      end else begin
        len = $urandom_range(1, 4);
      end

      for (int k = 0; k < len; k++) begin
        data = (k == 0) ? flags[7:0] : (k == 1) ? flags[15:8] : 8'($urandom());
        send_byte(data, k == len - 1);
      end

      // Back-pressure once from the result side, and once let everything drain.
      if (!held_once && sent_count >= NumRequests / 3) begin
        hold_req  = 1'b1;
        held_once = 1'b1;
      end
      if (!drained_once && sent_count >= (2 * NumRequests) / 3) begin
        wait_for_reports();
        drained_once = 1'b1;
      end
    end

    wait_for_reports();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
